/* hw/rtl/mks_pkg.sv */
// Shared types, phase codes and the key layout for the keypad scanner.
package mks_pkg;

  localparam int unsigned ColW = 4;
  localparam int unsigned RowW = 4;
  localparam int unsigned CharW = 7;
  localparam int unsigned CntW = 16;

  // Scanner phases.
  localparam logic [2:0] PH_SCAN     = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_RELEASE  = 3'd2;
  localparam logic [2:0] PH_SETTLE   = 3'd3;

  localparam logic [CntW-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [ColW-1:0] COLS_IDLE = 4'hF;
  localparam logic [2:0] SWEEP_ROWS = 3'd4;

  typedef struct packed {
    logic [2:0]       phase;
    logic [1:0]       current_row;
    logic [1:0]       found_column;
    logic [CntW-1:0]  wait_counter;
    logic [2:0]       clean_rows;
    logic [CharW-1:0] held_key;
  } mks_state_t;

  typedef struct packed {
    logic [RowW-1:0]  row_drive;
    logic             key_valid;
    logic [CharW-1:0] key_char;
  } mks_result_t;

  // Fixed layout: 789/ 456* 123- C0=+ by row and column.
  function automatic logic [CharW-1:0] key_lookup(logic [1:0] row, logic [1:0] col);
    logic [CharW-1:0] ch;
    case ({row, col})
      4'h0: ch = 7'h37;  // 7
      4'h1: ch = 7'h38;  // 8
      4'h2: ch = 7'h39;  // 9
      4'h3: ch = 7'h2F;  // /
      4'h4: ch = 7'h34;  // 4
      4'h5: ch = 7'h35;  // 5
      4'h6: ch = 7'h36;  // 6
      4'h7: ch = 7'h2A;  // *
      4'h8: ch = 7'h31;  // 1
      4'h9: ch = 7'h32;  // 2
      4'hA: ch = 7'h33;  // 3
      4'hB: ch = 7'h2D;  // -
      4'hC: ch = 7'h43;  // C
      4'hD: ch = 7'h30;  // 0
      4'hE: ch = 7'h3D;  // =
      4'hF: ch = 7'h2B;  // +
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

/* hw/rtl/mks_if.sv */
// Channel interfaces for the keypad scanner: column samples, results, configuration.
interface mks_in_if import mks_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ColW-1:0] column_lines;
  modport source (output valid, output column_lines, input ready);
  modport sink (input valid, input column_lines, output ready);
endinterface

interface mks_out_if import mks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RowW-1:0]  row_drive;
  logic             key_valid;
  logic [CharW-1:0] key_char;
  modport source (output valid, output row_drive, output key_valid, output key_char,
                  input ready);
  modport sink (input valid, input row_drive, input key_valid, input key_char,
                output ready);
endinterface

interface mks_cfg_if import mks_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CntW-1:0] debounce_ticks;
  modport source (output valid, output debounce_ticks, input ready);
  modport sink (input valid, input debounce_ticks, output ready);
endinterface

/* hw/rtl/mks_step.sv */
// Next-state and result logic for one scan tick of the keypad scanner.
module mks_step import mks_pkg::*; (
  input  mks_state_t       state,
  input  logic [ColW-1:0]  cols,
  input  logic [CntW-1:0]  debounce_ticks,
  output mks_state_t       state_nxt,
  output mks_result_t      result
);

  logic [CntW-1:0] limit;
  logic [CntW-1:0] count_inc;
  logic            count_done;
  logic [2:0]      clean_inc;
  logic [1:0]      first_low;
  logic            valid;
  logic [CharW-1:0] ch;

  // A zero debounce setting behaves as one tick.
  assign limit      = (debounce_ticks == '0) ? {{(CntW-1){1'b0}}, 1'b1} : debounce_ticks;
  assign count_inc  = state.wait_counter + {{(CntW-1){1'b0}}, 1'b1};
  assign count_done = (count_inc >= limit);
  assign clean_inc  = state.clean_rows + 3'd1;

  // Lowest numbered low column.
  always_comb begin
    if (!cols[0]) begin
      first_low = 2'd0;
    end else if (!cols[1]) begin
      first_low = 2'd1;
    end else if (!cols[2]) begin
      first_low = 2'd2;
    end else begin
      first_low = 2'd3;
    end
  end

  // Phase sequencing.
  always_comb begin
    state_nxt = state;
    valid     = 1'b0;
    ch        = '0;
    case (state.phase)
      PH_DEBOUNCE: begin
        state_nxt.wait_counter = count_inc;
        if (count_done) begin
          state_nxt.wait_counter = '0;
          if (!cols[state.found_column]) begin
            state_nxt.phase       = PH_RELEASE;
            state_nxt.current_row = 2'd0;
            state_nxt.clean_rows  = 3'd0;
          end else begin
            state_nxt.phase = PH_SCAN;
          end
        end
      end
      PH_RELEASE: begin
        if (cols == COLS_IDLE) begin
          state_nxt.clean_rows = clean_inc;
          if (clean_inc >= SWEEP_ROWS) begin
            state_nxt.clean_rows   = 3'd0;
            state_nxt.wait_counter = '0;
            state_nxt.current_row  = 2'd0;
            state_nxt.phase        = PH_SETTLE;
          end else begin
            state_nxt.current_row = state.current_row + 2'd1;
          end
        end else begin
          // A press during the sweep starts it over from the first row.
          state_nxt.clean_rows  = 3'd0;
          state_nxt.current_row = 2'd0;
        end
      end
      PH_SETTLE: begin
        state_nxt.wait_counter = count_inc;
        if (count_done) begin
          state_nxt.wait_counter = '0;
          valid                  = 1'b1;
          ch                     = state.held_key;
          state_nxt.phase        = PH_SCAN;
          state_nxt.current_row  = 2'd0;
        end
      end
      default: begin
        // Scanning, and any unused phase code.
        state_nxt.phase = PH_SCAN;
        if (cols != COLS_IDLE) begin
          state_nxt.found_column = first_low;
          state_nxt.held_key     = key_lookup(state.current_row, first_low);
          state_nxt.wait_counter = '0;
          state_nxt.phase        = PH_DEBOUNCE;
        end else begin
          state_nxt.current_row = state.current_row + 2'd1;
        end
      end
    endcase
  end

  // Drive the next row low, all others high.
  always_comb begin
    result.row_drive = ~(4'b0001 << state_nxt.current_row);
    result.key_valid = valid;
    result.key_char  = ch;
  end

endmodule

/* hw/rtl/matrix_keypad_scanner_core.sv */
// Top level of the debounced 4x4 matrix keypad scanner.
// Each accepted request is one scan tick: the active-low column levels sampled while
// the row from the previous result's row_drive was held low. Every request yields
// exactly one result, which carries the row to drive for the next tick and, on the
// tick a complete press, release and settle sequence ends, the key's ASCII code.
// A new request is taken every clock cycle while the output register is empty or
// its result is taken; each tick's result is combinational from the scanner state
// and lands in a single output register that holds it until the sink takes it.
// debounce_ticks is written over the configuration channel (reset value 20, zero acts
// as one) and should only change while no tick is in flight.
module matrix_keypad_scanner_core import mks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mks_in_if.sink    in_ch,
  mks_out_if.source out_ch,
  mks_cfg_if.sink   cfg_ch
);

  mks_state_t      state_r;
  mks_state_t      state_nxt;
  mks_result_t     result_nxt;
  mks_result_t     result_r;
  logic            out_valid_r;
  logic [CntW-1:0] debounce_r;
  logic            in_fire;

  // The output register frees up whenever its result is taken in the same cycle.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  mks_step u_step (
    .state          (state_r),
    .cols           (in_ch.column_lines),
    .debounce_ticks (debounce_r),
    .state_nxt      (state_nxt),
    .result         (result_nxt)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_ch.valid) begin
      debounce_r <= cfg_ch.debounce_ticks;
    end
  end

  // Scanner state advances once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_drive = result_r.row_drive;
  assign out_ch.key_valid = result_r.key_valid;
  assign out_ch.key_char  = result_r.key_char;

endmodule
